// File: sv/depth_keyed_mix_hash64_assert.svh
// assertion macros shared by the hash pipeline
`ifndef DEPTH_KEYED_MIX_HASH64_ASSERT_SVH
`define DEPTH_KEYED_MIX_HASH64_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DKMH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("depth_keyed_mix_hash64: same-cycle check failed");

// next-cycle implication, checked outside reset
`define DKMH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("depth_keyed_mix_hash64: next-cycle check failed");

`endif

// File: sv/dkmh_pkg.sv
package dkmh_pkg;

  // word and key widths
  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int NKEY     = 4;
  localparam int KEY_IW   = 2;
  localparam int ADDR_W   = 5;

  // pipeline shape
  localparam int NSTG     = 16;
  localparam int NRND     = 7;

  // integer square root unit
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = 16;
  localparam int ROOT_STAGES = 4;
  localparam int ROOT_STEPS  = 4;

  // mixing constants
  localparam logic [63:0] GOLD_MUL  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] DEPTH_MUL = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] EPS_MUL   = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] FIN_MUL   = 64'hD6E8FEB86659FD93;

  // key register indexes
  typedef enum logic [KEY_IW-1:0] {KEY_0, KEY_1, KEY_2, KEY_3} key_idx_t;

  // split product, low word times low word plus the two cross terms
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  // square root iteration state
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sq_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = 64'(a[31:0]) * 64'(b[31:0]);
    r.lh = a[31:0] * b[63:32];
    r.hl = a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'd0};
  endfunction

  function automatic logic [63:0] eps_prime(input logic [2:0] i);
    logic [63:0] r;
    unique case (i)
      3'd0:    r = 64'd3;
      3'd1:    r = 64'd5;
      3'd2:    r = 64'd7;
      3'd3:    r = 64'd11;
      3'd4:    r = 64'd13;
      3'd5:    r = 64'd17;
      default: r = 64'd19;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] eps_const(input logic [2:0] i);
    logic [63:0] r;
    r = eps_prime(i) * EPS_MUL;
    return r;
  endfunction

  function automatic logic [5:0] fin_rot(input logic [1:0] k);
    logic [5:0] r;
    unique case (k)
      2'd0:    r = 6'd13;
      2'd1:    r = 6'd23;
      default: r = 6'd43;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] fin_const(input logic [1:0] k);
    logic [63:0] r;
    unique case (k)
      2'd0:    r = 64'd19 * FIN_MUL;
      2'd1:    r = 64'd29 * FIN_MUL;
      default: r = 64'd47 * FIN_MUL;
    endcase
    return r;
  endfunction

  // 6-bit value mod 3: 4 is 1 mod 3, so bit pairs add up
  function automatic logic [1:0] mod3(input logic [5:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

  // depth from bit length, popcount and the shifted middle
  function automatic logic [5:0] depth_mix(input logic [6:0] bl, input logic [6:0] pc,
                                           input logic [5:0] mid);
    return bl[5:0] ^ {pc[4:0], 1'b0} ^ mid;
  endfunction

  function automatic logic [5:0] depth16(input logic [ROOT_W-1:0] v);
    logic [6:0] bl;
    logic [6:0] pc;
    logic [5:0] mid;
    bl = '0;
    pc = '0;
    for (int i = 0; i < ROOT_W; i++) begin
      if (v[i]) bl = 7'(i + 1);
      pc = pc + 7'(v[i]);
    end
    mid = 6'(v >> bl[4:1]);
    return depth_mix(bl, pc, mid);
  endfunction

endpackage

// File: sv/dkmh_root.sv
module dkmh_root
  import dkmh_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   sq,
  output logic [ROOT_W-1:0] root
);

  // one restoring square root digit, k counts from the top pair of bits
  function automatic sq_t root_step(input sq_t s, input int k);
    sq_t r;
    logic [SQ_W-1:0] bit_w;
    logic [SQ_W-1:0] trial;
    bit_w = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    trial = s.res + bit_w;
    r = s;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.res = (s.res >> 1) + bit_w;
    end else begin
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  sq_t stage [ROOT_STAGES];
  sq_t stage_in [ROOT_STAGES];
  sq_t stage_next [ROOT_STAGES];

  // four digits per register stage
  for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_stage
    // first stage starts from the raw square, later ones from the stage before
    if (j == 0) begin : g_head
      assign stage_in[j] = '{rem: sq, res: '0};
    end else begin : g_body
      assign stage_in[j] = stage[j-1];
    end

    always_comb begin
      sq_t s;
      s = stage_in[j];
      for (int t = 0; t < ROOT_STEPS; t++) begin
        s = root_step(s, j * ROOT_STEPS + t);
      end
      stage_next[j] = s;
    end

    always_ff @(posedge clk) begin
      if (en) stage[j] <= stage_next[j];
    end
  end

  assign root = stage[ROOT_STAGES-1].res[ROOT_W-1:0];

endmodule

// File: sv/depth_keyed_mix_hash64.sv
// channel   dir  beat content
// s_*       in   tdata[63:0] = data_word
// m_*       out  tdata[63:0] = hash_word
// apb       in   key_0..key_3 at byte address 0, 8, 16, 24, 64-bit data
//
// sixteen register stages; one beat enters per cycle while the output is not stalled
// the depth is set by the 64-bit multiplies, each cut into 32x32 partial products
// plus a registered add, and by the square root unit at four digits per stage
// rst clears stage valids and the keys; payload registers are not reset
// a stall on m_tready freezes every stage at once, so nothing is lost or repeated
`include "depth_keyed_mix_hash64_assert.svh"

module depth_keyed_mix_hash64
  import dkmh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // [63:0] data_word
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // [63:0] hash_word
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [WORD_W-1:0] key [NKEY];
  logic              cfg_wr;

  // key registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = key[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NKEY; i++) key[i] <= '0;
    end else if (cfg_wr) begin
      key[paddr[4:3]] <= pwdata;
    end
  end

  // stage valids, one global advance
  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv      = !vld[NSTG-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  // payload registers
  logic [63:0]       w1, w2, w7;
  logic [6:0]        bl1, pc1;
  logic [31:0]       sql1, sqh1, sq2;
  logic [5:0]        d2, d7, d8, d9, d10, d11, d12, g7;
  logic [63:0]       w_dly [ROOT_STAGES];
  logic [5:0]        d_dly [ROOT_STAGES];
  logic [ROOT_W-1:0] root6;
  logic [63:0]       a8, dm9, p10, p11, z12, z13, y15, out16;
  pp_t               pa9, pz14;
  pp_t               lp11 [NRND];
  logic [63:0]       q11 [NRND];
  logic [1:0]        k12, k13;
  logic [5:0]        amt13, amt14, amt15;
  logic [63:0]       eps;
  logic [63:0]       z_sh;
  logic [5:0]        rp;
  logic [127:0]      rot_out;

  dkmh_root u_root (
    .clk  (clk),
    .en   (adv),
    .sq   (sq2),
    .root (root6)
  );

  // epsilon rounds: all seven lanes in parallel, kept by depth
  always_comb begin
    logic [63:0]  c;
    logic [127:0] cc;
    eps = '0;
    for (int i = 0; i < NRND; i++) begin
      c  = pp_sum(lp11[i]) ^ q11[i] ^ key[2'(i)];
      cc = {c, c} << (13 + 7 * i);
      if (6'(i) <= d11) eps = eps ^ cc[127:64];
    end
  end

  // final xor-shift picked by depth mod 3
  always_comb begin
    logic [63:0] z1;
    rp   = fin_rot(k12);
    z1   = z12 ^ (z12 << rp);
    z_sh = z1 ^ (z1 >> rp[5:1]);
  end

  assign rot_out = {y15, y15} << amt15;

  always_ff @(posedge clk) begin
    if (adv) begin
      // bit length, popcount, squares of the two 16-bit halves of the low word
      w1   <= s_tdata;
      bl1  <= bit_len64(s_tdata);
      pc1  <= pop64(s_tdata);
      sql1 <= 32'(s_tdata[15:0]) * 32'(s_tdata[15:0]);
      sqh1 <= 32'(s_tdata[31:16]) * 32'(s_tdata[31:16]);
      // word depth and wrapped sum of squares
      w2   <= w1;
      d2   <= depth_mix(bl1, pc1, 6'(w1 >> bl1[6:1]));
      sq2  <= sql1 + sqh1;
      // side data alongside the square root unit
      w_dly[0] <= w2;
      d_dly[0] <= d2;
      for (int i = 1; i < ROOT_STAGES; i++) begin
        w_dly[i] <= w_dly[i-1];
        d_dly[i] <= d_dly[i-1];
      end
      // magnitude depth
      w7 <= w_dly[ROOT_STAGES-1];
      d7 <= d_dly[ROOT_STAGES-1];
      g7 <= depth16(root6);
      // offset word
      a8 <= w7 + 64'(g7);
      d8 <= d7;
      // golden multiply, partial products
      pa9 <= pp_mul(a8, GOLD_MUL);
      dm9 <= DEPTH_MUL * 64'(d8);
      d9  <= d8;
      p10 <= pp_sum(pa9) ^ dm9;
      d10 <= d9;
      // round products
      for (int i = 0; i < NRND; i++) begin
        lp11[i] <= pp_mul(p10, eps_const(3'(i)));
        q11[i]  <= (p10 >> (i + 1)) * eps_prime(3'(i));
      end
      p11 <= p10;
      d11 <= d10;
      // round merge
      z12 <= p11 ^ eps;
      d12 <= d11;
      k12 <= mod3(d11);
      // xor-shift and final rotate amount
      z13   <= z_sh;
      k13   <= k12;
      amt13 <= d12 ^ rp;
      // final multiply
      pz14  <= pp_mul(z13, fin_const(k13));
      amt14 <= amt13;
      y15   <= pp_sum(pz14) ^ key[amt14[1:0]];
      amt15 <= amt14;
      // final rotate into the output register
      out16 <= rot_out[127:64];
    end
  end

  assign m_tdata = out16;

  // checks
  `DKMH_ASSERT_NXT(a_stall_freeze, !adv, $stable(vld))
  `DKMH_ASSERT_NXT(a_beat_enters, s_tvalid && s_tready, vld[0])
  `DKMH_ASSERT_NXT(a_idle_bubble, adv && !s_tvalid, !vld[0])
  `DKMH_ASSERT_NXT(a_key0_write, cfg_wr && paddr[4:3] == KEY_0, key[KEY_0] == $past(pwdata))

endmodule
